// File: design/bta_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// bta_pkg: shared definitions for the bakery ticket arbiter
// Sizes, field widths, function and status codes, and the scan unit interface.
// ============================================================================
package bta_pkg;

    localparam int REQUESTERS  = 16;
    localparam int TICKET_BITS = 16;

    localparam int IDX_W = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
    localparam int CNT_W = $clog2(REQUESTERS + 1);

    localparam int FUNC_W   = 1;
    localparam int REQ_W    = 4;
    localparam int HOLDER_W = 4;
    localparam int GIVEN_W  = 16;
    localparam int STATUS_W = 1;

    localparam logic [FUNC_W-1:0]   FUNC_REQUEST    = 1'b0;
    localparam logic [FUNC_W-1:0]   FUNC_RELEASE    = 1'b1;
    localparam logic [STATUS_W-1:0] STATUS_OK       = 1'b0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 1'b1;

    typedef logic [TICKET_BITS-1:0] ticket_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;

    typedef enum logic {
        SCAN_MAX,
        SCAN_MIN
    } scan_mode_t;

    typedef struct packed {
        logic       clear;
        logic       step;
        scan_mode_t mode;
    } scan_ctrl_t;

    typedef struct packed {
        logic    found;
        ticket_t best_ticket;
        idx_t    best_index;
    } scan_stat_t;

endpackage

// File: design/bakery_ticket_arbiter.sv
`timescale 1ns / 1ps
// ============================================================================
// bakery_ticket_arbiter: ticket-based lock arbiter
// Request takes largest ticket plus one; release clears; reports the holder.
// ============================================================================
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | func, requester
//  out     | output    | out_valid / out_ready| holder_valid, holder_index,
//          |           |                      | ticket_given, status
//
//  A request in range makes two passes (largest ticket, then smallest
//  nonzero), a release or an ignored requester only the second: each pass
//  reads the ticket store one entry a cycle through the single compare unit,
//  via its registered read port. in_ready returns as the result is loaded.
//  Reset clears all tickets at once; no sweep is needed.
//  A result waits in the output register; the next transaction is taken
//  meanwhile, and only its own result waits on out_ready.
// ============================================================================
module bakery_ticket_arbiter
    import bta_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [FUNC_W-1:0]   func,
    input  logic [REQ_W-1:0]    requester,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                holder_valid,
    output logic [HOLDER_W-1:0] holder_index,
    output logic [GIVEN_W-1:0]  ticket_given,
    output logic [STATUS_W-1:0] status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAX,
        S_WRITE,
        S_MIN,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    cnt_t                cnt_reg, cnt_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    idx_t                who_reg, who_next;
    ticket_t             given_reg, given_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;
    logic                out_valid_reg, out_valid_next;
    logic                holder_valid_reg, holder_valid_next;
    logic [HOLDER_W-1:0] holder_index_reg, holder_index_next;
    logic [GIVEN_W-1:0]  ticket_given_reg, ticket_given_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                in_range;
    logic                wr_en;
    ticket_t             wr_data;
    logic                rd_en;
    ticket_t             rd_data;
    idx_t                data_idx;
    scan_ctrl_t          scan_ctrl;
    scan_stat_t          scan_stat;
    logic [TICKET_BITS:0] next_ticket;

    assign in_range    = (32'(requester) < 32'(REQUESTERS));
    assign next_ticket = {1'b0, scan_stat.best_ticket} + (TICKET_BITS + 1)'(1);
    assign data_idx    = idx_t'(cnt_reg - cnt_t'(1));

    bta_ticket_file u_tickets (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_idx  (who_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_idx  (cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    bta_scan_unit u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (scan_ctrl),
        .ticket (rd_data),
        .index  (data_idx),
        .stat   (scan_stat)
    );

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        func_next         = func_reg;
        who_next          = who_reg;
        given_next        = given_reg;
        stat_next         = stat_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        holder_valid_next = holder_valid_reg;
        holder_index_next = holder_index_reg;
        ticket_given_next = ticket_given_reg;
        status_next       = status_reg;
        wr_en             = 1'b0;
        wr_data           = '0;
        rd_en             = 1'b0;
        scan_ctrl.clear   = 1'b0;
        scan_ctrl.step    = 1'b0;
        scan_ctrl.mode    = (state_reg == S_MIN) ? SCAN_MIN : SCAN_MAX;
        in_ready          = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next       = func;
                    who_next        = idx_t'(requester);
                    given_next      = '0;
                    stat_next       = STATUS_OK;
                    cnt_next        = '0;
                    scan_ctrl.clear = 1'b1;
                    if (!in_range)
                    begin
                        state_next = S_MIN;
                    end
                    else if (func == FUNC_REQUEST)
                    begin
                        state_next = S_MAX;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_MAX, S_MIN:
            begin
                rd_en          = (cnt_reg < cnt_t'(REQUESTERS));
                scan_ctrl.step = (cnt_reg != '0);
                cnt_next       = cnt_reg + cnt_t'(1);
                if (cnt_reg == cnt_t'(REQUESTERS))
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == S_MAX) ? S_WRITE : S_DONE;
                end
            end
            S_WRITE:
            begin
                if (func_reg == FUNC_REQUEST)
                begin
                    if (next_ticket[TICKET_BITS])
                    begin
                        stat_next = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_data    = next_ticket[TICKET_BITS-1:0];
                        given_next = next_ticket[TICKET_BITS-1:0];
                    end
                end
                else
                begin
                    wr_en = 1'b1;
                end
                scan_ctrl.clear = 1'b1;
                cnt_next        = '0;
                state_next      = S_MIN;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    holder_valid_next = scan_stat.found;
                    holder_index_next = HOLDER_W'(scan_stat.best_index);
                    ticket_given_next = GIVEN_W'(given_reg);
                    status_next       = stat_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            func_reg         <= FUNC_REQUEST;
            who_reg          <= '0;
            given_reg        <= '0;
            stat_reg         <= STATUS_OK;
            out_valid_reg    <= 1'b0;
            holder_valid_reg <= 1'b0;
            holder_index_reg <= '0;
            ticket_given_reg <= '0;
            status_reg       <= STATUS_OK;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            func_reg         <= func_next;
            who_reg          <= who_next;
            given_reg        <= given_next;
            stat_reg         <= stat_next;
            out_valid_reg    <= out_valid_next;
            holder_valid_reg <= holder_valid_next;
            holder_index_reg <= holder_index_next;
            ticket_given_reg <= ticket_given_next;
            status_reg       <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign holder_valid = holder_valid_reg;
    assign holder_index = holder_index_reg;
    assign ticket_given = ticket_given_reg;
    assign status       = status_reg;

endmodule

// File: design/bta_ticket_file.sv
`timescale 1ns / 1ps
// ============================================================================
// bta_ticket_file: ticket store
// One write port, one registered read port; entries never written read as zero.
// ============================================================================
module bta_ticket_file
    import bta_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  idx_t    wr_idx,
    input  ticket_t wr_data,
    input  logic    rd_en,
    input  idx_t    rd_idx,
    output ticket_t rd_data
);

    ticket_t                 mem [REQUESTERS];
    logic [REQUESTERS-1:0]   written_reg;
    ticket_t                 rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= written_reg[rd_idx] ? mem[rd_idx] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr_en)
        begin
            written_reg[wr_idx] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/bta_scan_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// bta_scan_unit: shared compare unit
// Folds one ticket per step into a running largest or smallest-nonzero result.
// ============================================================================
module bta_scan_unit
    import bta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  scan_ctrl_t ctrl,
    input  ticket_t    ticket,
    input  idx_t       index,
    output scan_stat_t stat
);

    logic    found_reg;
    ticket_t best_reg;
    idx_t    index_reg;
    logic    better;

    always_comb
    begin
        if (ctrl.mode == SCAN_MAX)
        begin
            better = (ticket > best_reg);
        end
        else
        begin
            better = (ticket != '0) && (!found_reg || (ticket < best_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            best_reg  <= '0;
            index_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            found_reg <= 1'b0;
            best_reg  <= '0;
            index_reg <= '0;
        end
        else if (ctrl.step && better)
        begin
            found_reg <= 1'b1;
            best_reg  <= ticket;
            index_reg <= index;
        end
    end

    assign stat.found       = found_reg;
    assign stat.best_ticket = best_reg;
    assign stat.best_index  = index_reg;

endmodule

// File: design/bta_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// bta_checker: port-level checks for the bakery ticket arbiter
// Watches the top-level ports only; attached by bind.
// ============================================================================
module bta_checker
    import bta_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [FUNC_W-1:0]   func,
    input logic [REQ_W-1:0]    requester,
    input logic                out_valid,
    input logic                out_ready,
    input logic                holder_valid,
    input logic [HOLDER_W-1:0] holder_index,
    input logic [GIVEN_W-1:0]  ticket_given,
    input logic [STATUS_W-1:0] status
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(holder_valid)
            && $stable(holder_index) && $stable(ticket_given) && $stable(status))
    else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_OVERFLOW) |-> ticket_given == '0)
    else $error("ticket given on a refused request");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !holder_valid |-> holder_index == '0)
    else $error("holder index set with no holder");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ticket_given != '0) |-> holder_valid && (status == STATUS_OK))
    else $error("ticket given but no holder reported");

endmodule

bind bakery_ticket_arbiter bta_checker u_bta_checker (.*);

// File: dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: testbench for the bakery ticket arbiter
// Drives request and release transactions with random gaps and output stalls.
// Tracks the ticket book alongside the block and checks every result field by
// field. Climbs the tickets over four rounds of repeat requests.
// ============================================================================
module tb;
    import bta_pkg::*;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [REQ_W-1:0]  requester;
    } lock_op_t;

    typedef struct packed {
        logic                holder_valid;
        logic [HOLDER_W-1:0] holder_index;
        logic [GIVEN_W-1:0]  ticket_given;
        logic [STATUS_W-1:0] status;
    } lock_grant_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [FUNC_W-1:0]   func;
    logic [REQ_W-1:0]    requester;
    logic                out_valid;
    logic                out_ready;
    logic                holder_valid;
    logic [HOLDER_W-1:0] holder_index;
    logic [GIVEN_W-1:0]  ticket_given;
    logic [STATUS_W-1:0] status;

    ticket_t     ticket_book [REQUESTERS];
    lock_op_t    op_queue [$];
    lock_grant_t grants_due [$];
    int          ops_queued;
    int          ops_taken;
    int          fail_count;
    bit          send_idle;
    bit          recv_idle;

    bakery_ticket_arbiter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .requester    (requester),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .holder_valid (holder_valid),
        .holder_index (holder_index),
        .ticket_given (ticket_given),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("FAIL");
        $finish;
    end

    function automatic int lead_requester();
        int      lead;
        ticket_t best;
        lead = -1;
        best = '0;
        for (int i = 0; i < REQUESTERS; i++)
        begin
            if (ticket_book[i] != '0 && (lead < 0 || ticket_book[i] < best))
            begin
                lead = i;
                best = ticket_book[i];
            end
        end
        return lead;
    endfunction

    function automatic lock_grant_t apply_lock_op(input lock_op_t op);
        lock_grant_t          g;
        ticket_t              top;
        logic [TICKET_BITS:0] next_ticket;
        int                   lead;
        g = '0;
        g.status = STATUS_OK;
        if (int'(op.requester) < REQUESTERS)
        begin
            if (op.func == FUNC_REQUEST)
            begin
                top = '0;
                for (int i = 0; i < REQUESTERS; i++)
                begin
                    if (ticket_book[i] > top)
                        top = ticket_book[i];
                end
                next_ticket = {1'b0, top} + 1'b1;
                if (next_ticket[TICKET_BITS])
                    g.status = STATUS_OVERFLOW;
                else
                begin
                    ticket_book[op.requester] = next_ticket[TICKET_BITS-1:0];
                    g.ticket_given = GIVEN_W'(next_ticket[TICKET_BITS-1:0]);
                end
            end
            else
                ticket_book[op.requester] = '0;
        end
        lead = lead_requester();
        g.holder_valid = (lead >= 0);
        g.holder_index = (lead >= 0) ? HOLDER_W'(lead) : '0;
        return g;
    endfunction

    // hold each transaction until taken; keep valid high across back-to-back items
    initial
    begin : op_driver
        lock_op_t op;
        int       gap;
        in_valid  = 1'b0;
        func      = FUNC_REQUEST;
        requester = '0;
        @(negedge clk);
        forever
        begin
            if (op_queue.size() == 0)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            else
            begin
                op = op_queue.pop_front();
                gap = send_idle ? $urandom_range(0, 14) : 0;
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                in_valid  <= 1'b1;
                func      <= op.func;
                requester <= op.requester;
                do @(posedge clk); while (!in_ready);
                grants_due.push_back(apply_lock_op(op));
                ops_taken++;
                @(negedge clk);
            end
        end
    end

    initial
    begin : grant_checker
        lock_grant_t want;
        int          stall;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = recv_idle ? $urandom_range(0, 14) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (grants_due.size() == 0)
            begin
                $display("%0t: result expected none actual holder_valid %0d holder_index %0d",
                         $time, holder_valid, holder_index);
                fail_count++;
            end
            else
            begin
                want = grants_due.pop_front();
                if (holder_valid !== want.holder_valid)
                begin
                    $display("%0t: holder_valid expected %0d actual %0d",
                             $time, want.holder_valid, holder_valid);
                    fail_count++;
                end
                if (holder_index !== want.holder_index)
                begin
                    $display("%0t: holder_index expected %0d actual %0d",
                             $time, want.holder_index, holder_index);
                    fail_count++;
                end
                if (ticket_given !== want.ticket_given)
                begin
                    $display("%0t: ticket_given expected %0d actual %0d",
                             $time, want.ticket_given, ticket_given);
                    fail_count++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                    fail_count++;
                end
            end
            @(negedge clk);
        end
    end

    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [REQ_W-1:0] r);
        lock_op_t op;
        op.func      = f;
        op.requester = r;
        ops_queued++;
        op_queue.push_back(op);
        wait (ops_taken == ops_queued);
    endtask

    task automatic wait_for_grants();
        while (grants_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic release_everyone();
        for (int i = 0; i < REQUESTERS; i++)
            send_item(FUNC_RELEASE, REQ_W'(i));
    endtask

    task automatic test_queue_order();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_item(FUNC_RELEASE, 4'd0);
        send_item(FUNC_REQUEST, 4'd0);
        send_item(FUNC_REQUEST, 4'd15);
        send_item(FUNC_REQUEST, 4'd5);
        send_item(FUNC_REQUEST, 4'd10);
        send_item(FUNC_REQUEST, 4'd0);
        send_item(FUNC_RELEASE, 4'd3);
        send_item(FUNC_RELEASE, 4'd15);
        send_item(FUNC_RELEASE, 4'd15);
        send_item(FUNC_REQUEST, 4'd15);
        send_item(FUNC_RELEASE, 4'd5);
        send_item(FUNC_RELEASE, 4'd10);
        send_item(FUNC_REQUEST, 4'd10);
        send_item(FUNC_RELEASE, 4'd0);
        send_item(FUNC_RELEASE, 4'd15);
        send_item(FUNC_RELEASE, 4'd10);
        send_item(FUNC_REQUEST, 4'd7);
        send_item(FUNC_REQUEST, 4'd8);
        send_item(FUNC_RELEASE, 4'd8);
        send_item(FUNC_RELEASE, 4'd7);
        wait_for_grants();
    endtask

    // climb the tickets over several rounds; re-ticket, hand back and drain
    task automatic test_ticket_climb();
        int lead;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        for (int i = 0; i < 4 * REQUESTERS; i++)
            send_item(FUNC_REQUEST, REQ_W'(i % REQUESTERS));
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_item(FUNC_REQUEST, 4'd3);
        send_item(FUNC_REQUEST, 4'd14);
        send_item(FUNC_RELEASE, 4'd14);
        send_item(FUNC_REQUEST, 4'd2);
        send_item(FUNC_REQUEST, 4'd2);
        lead = lead_requester();
        send_item(FUNC_RELEASE, REQ_W'(lead));
        send_item(FUNC_REQUEST, 4'd9);
        release_everyone();
        send_item(FUNC_REQUEST, 4'd7);
        send_item(FUNC_RELEASE, 4'd7);
        wait_for_grants();
    endtask

    // mostly lock traffic: requests, the holder handing back, stray releases
    task automatic test_random_traffic(input int count, input bit s_idle, input bit r_idle);
        int pick;
        int who;
        int lead;
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            who  = $urandom_range(0, REQUESTERS - 1);
            lead = lead_requester();
            if (pick < 50)
                send_item(FUNC_REQUEST, REQ_W'(who));
            else if (pick < 85 && lead >= 0)
                send_item(FUNC_RELEASE, REQ_W'(lead));
            else
                send_item(FUNC_RELEASE, REQ_W'(who));
        end
        wait_for_grants();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        ops_queued = 0;
        ops_taken  = 0;
        fail_count = 0;
        send_idle  = 1'b0;
        recv_idle  = 1'b0;
        for (int i = 0; i < REQUESTERS; i++)
            ticket_book[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_queue_order();
        test_ticket_climb();
        test_random_traffic(300, 1'b1, 1'b1);
        test_random_traffic(130, 1'b0, 1'b0);
        test_random_traffic(130, 1'b1, 1'b0);
        test_random_traffic(280, 1'b0, 1'b1);

        wait_for_grants();
        repeat (2 * REQUESTERS + 20) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
